### rtl/core/mm_pkg.sv
`timescale 1ns / 1ps

package mm_pkg;

   localparam int MAX_DIM     = 4;
   localparam int FRAC_BITS   = 16;
   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int VALUE_W     = 32;
   localparam int INDEX_W     = 4;
   localparam int OPCODE_W    = 2;
   localparam int DIM_REG_W   = 3;
   localparam int DIM_W       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int CNT_W       = $clog2(MAX_DIM + 1);
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int PROD_W      = 2 * VALUE_W;
   localparam int ACC_W       = PROD_W + DIM_W;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [OPCODE_W-1:0] {
      OP_WRITE_A = 2'd0,
      OP_WRITE_B = 2'd1,
      OP_COMPUTE = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      REG_ROW_COUNT  = 2'd0,
      REG_INNER_SIZE = 2'd1,
      REG_COL_COUNT  = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic               wr_a;
      logic               wr_b;
      logic [ADDR_W-1:0]  wr_addr;
      logic               issue;
      logic [ADDR_W-1:0]  a_addr;
      logic [ADDR_W-1:0]  b_addr;
      logic               first;
      logic               last_k;
      logic [INDEX_W-1:0] res_index;
      logic               res_last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pipe_busy;
   } status_type;

   // tag that travels with one product term
   typedef struct packed {
      logic               valid;
      logic               first;
      logic               last_k;
      logic [INDEX_W-1:0] index;
      logic               last;
   } tag_type;

   // register value 0 acts as 1, above MAX_DIM acts as MAX_DIM
   function automatic logic [CNT_W-1:0] eff_dim(input logic [DIM_REG_W-1:0] r);
      logic [CNT_W-1:0] d;
      if (r == '0)
         d = CNT_W'(1);
      else if (int'(r) > MAX_DIM)
         d = CNT_W'(MAX_DIM);
      else
         d = CNT_W'(r);
      return d;
   endfunction

endpackage

### rtl/core/mm_ctrl.sv
`timescale 1ns / 1ps

module mm_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [mm_pkg::OPCODE_W-1:0]     opcode,
   input  logic [mm_pkg::INDEX_W-1:0]      element_index,
   input  logic [mm_pkg::DIM_REG_W-1:0]    row_count,
   input  logic [mm_pkg::DIM_REG_W-1:0]    inner_size,
   input  logic [mm_pkg::DIM_REG_W-1:0]    col_count,
   input  mm_pkg::status_type              status,
   output logic                            busy,
   output mm_pkg::cmd_type                 cmd
);

   mm_pkg::ctrl_state_type          state_ff, state_in;
   logic [mm_pkg::DIM_W-1:0]        i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [mm_pkg::CNT_W-1:0]        rows_ff, rows_in, inner_ff, inner_in, cols_ff, cols_in;
   logic                            k_last, j_last, i_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff     <= i_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      rows_ff  <= rows_in;
      inner_ff <= inner_in;
      cols_ff  <= cols_in;
   end

   assign k_last = (mm_pkg::CNT_W'(k_ff) + mm_pkg::CNT_W'(1)) == inner_ff;
   assign j_last = (mm_pkg::CNT_W'(j_ff) + mm_pkg::CNT_W'(1)) == cols_ff;
   assign i_last = (mm_pkg::CNT_W'(i_ff) + mm_pkg::CNT_W'(1)) == rows_ff;

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      rows_in  = rows_ff;
      inner_in = inner_ff;
      cols_in  = cols_ff;

      cmd           = '0;
      cmd.wr_addr   = element_index[mm_pkg::ADDR_W-1:0];
      cmd.a_addr    = mm_pkg::ADDR_W'(int'(i_ff) * int'(inner_ff) + int'(k_ff));
      cmd.b_addr    = mm_pkg::ADDR_W'(int'(k_ff) * int'(cols_ff) + int'(j_ff));
      cmd.first     = (k_ff == '0);
      cmd.last_k    = k_last;
      cmd.res_index = mm_pkg::INDEX_W'(int'(i_ff) * int'(cols_ff) + int'(j_ff));
      cmd.res_last  = k_last && j_last && i_last;

      case (state_ff)
         mm_pkg::ST_IDLE: begin
            if (start) begin
               case (opcode)
                  mm_pkg::OP_WRITE_A: begin
                     cmd.wr_a = (int'(element_index) < mm_pkg::STORE_DEPTH);
                  end
                  mm_pkg::OP_WRITE_B: begin
                     cmd.wr_b = (int'(element_index) < mm_pkg::STORE_DEPTH);
                  end
                  mm_pkg::OP_COMPUTE: begin
                     rows_in  = mm_pkg::eff_dim(row_count);
                     inner_in = mm_pkg::eff_dim(inner_size);
                     cols_in  = mm_pkg::eff_dim(col_count);
                     i_in     = '0;
                     j_in     = '0;
                     k_in     = '0;
                     state_in = mm_pkg::ST_ISSUE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         mm_pkg::ST_ISSUE: begin
            cmd.issue = 1'b1;
            if (!k_last) begin
               k_in = k_ff + 1'b1;
            end else begin
               k_in = '0;
               if (!j_last) begin
                  j_in = j_ff + 1'b1;
               end else begin
                  j_in = '0;
                  if (i_last)
                     state_in = mm_pkg::ST_DRAIN;
                  else
                     i_in = i_ff + 1'b1;
               end
            end
         end
         mm_pkg::ST_DRAIN: begin
            if (!status.pipe_busy)
               state_in = mm_pkg::ST_IDLE;
         end
         default: begin
            state_in = mm_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != mm_pkg::ST_IDLE);

endmodule

### rtl/core/mm_datapath.sv
`timescale 1ns / 1ps

module mm_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  mm_pkg::cmd_type                    cmd,
   input  logic signed [mm_pkg::VALUE_W-1:0]  element_value,
   output mm_pkg::status_type                 status,
   output logic                               result_valid,
   output logic signed [mm_pkg::VALUE_W-1:0]  result_value,
   output logic [mm_pkg::INDEX_W-1:0]         result_index,
   output logic                               result_last
);

   localparam logic signed [mm_pkg::ACC_W-1:0] SAT_MAX =
      mm_pkg::ACC_W'((64'sd1 <<< (mm_pkg::VALUE_W - 1)) - 64'sd1);
   localparam logic signed [mm_pkg::ACC_W-1:0] SAT_MIN =
      mm_pkg::ACC_W'(-(64'sd1 <<< (mm_pkg::VALUE_W - 1)));

   logic signed [mm_pkg::VALUE_W-1:0] mem_a [mm_pkg::STORE_DEPTH];
   logic signed [mm_pkg::VALUE_W-1:0] mem_b [mm_pkg::STORE_DEPTH];

   logic signed [mm_pkg::VALUE_W-1:0] a_rd_ff, b_rd_ff;
   mm_pkg::tag_type                   s0_ff, s0_in, s1_ff, s2_ff, s2_in;
   logic signed [mm_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic signed [mm_pkg::ACC_W-1:0]   acc_ff, acc_in, shifted;
   logic signed [mm_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [mm_pkg::INDEX_W-1:0]        index_ff;
   logic                              last_ff;
   logic                              strobe_ff;

   // element stores, registered read
   always_ff @(posedge clock) begin
      if (cmd.wr_a)
         mem_a[cmd.wr_addr] <= element_value;
      if (cmd.wr_b)
         mem_b[cmd.wr_addr] <= element_value;
      a_rd_ff <= mem_a[cmd.a_addr];
      b_rd_ff <= mem_b[cmd.b_addr];
   end

   always_comb begin
      s0_in        = '0;
      s0_in.valid  = cmd.issue;
      s0_in.first  = cmd.first;
      s0_in.last_k = cmd.last_k;
      s0_in.index  = cmd.res_index;
      s0_in.last   = cmd.res_last;

      prod_in = a_rd_ff * b_rd_ff;

      if (s1_ff.first)
         acc_in = mm_pkg::ACC_W'(prod_ff);
      else
         acc_in = acc_ff + mm_pkg::ACC_W'(prod_ff);

      s2_in       = s1_ff;
      s2_in.valid = s1_ff.valid && s1_ff.last_k;

      // floor shift then clamp to the result range
      shifted = acc_ff >>> mm_pkg::FRAC_BITS;
      if (shifted > SAT_MAX)
         value_in = SAT_MAX[mm_pkg::VALUE_W-1:0];
      else if (shifted < SAT_MIN)
         value_in = SAT_MIN[mm_pkg::VALUE_W-1:0];
      else
         value_in = shifted[mm_pkg::VALUE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff     <= '0;
         s1_ff     <= '0;
         s2_ff     <= '0;
         strobe_ff <= 1'b0;
      end else begin
         s0_ff     <= s0_in;
         s1_ff     <= s0_ff;
         s2_ff     <= s2_in;
         strobe_ff <= s2_ff.valid;
      end
      prod_ff <= prod_in;
      if (s1_ff.valid)
         acc_ff <= acc_in;
      value_ff <= value_in;
      index_ff <= s2_ff.index;
      last_ff  <= s2_ff.last;
   end

   assign status.pipe_busy = s0_ff.valid || s1_ff.valid || s2_ff.valid;

   assign result_valid = strobe_ff;
   assign result_value = value_ff;
   assign result_index = index_ff;
   assign result_last  = last_ff;

endmodule

### rtl/core/matrix_multiply.sv
`timescale 1ns / 1ps
// element write, while idle: one word per cycle, busy stays low, stored at
// the accept edge; compute: busy until the last result has been strobed, and
// a result is sent once all its inner products are accumulated (one product
// per cycle through the single 32x32 multiplier and its accumulator)
// results are strobed for one cycle on rsp_valid; the receiver cannot stall
// reset clears the controller, the pipeline valids and the size registers to 4

module matrix_multiply (
   input  logic                                clock,
   input  logic                                reset,

   // command channel
   input  logic                                start,
   output logic                                busy,
   input  logic [mm_pkg::OPCODE_W-1:0]         req_opcode,
   input  logic [mm_pkg::INDEX_W-1:0]          req_element_index,
   input  logic signed [mm_pkg::VALUE_W-1:0]   req_element_value,

   // result channel
   output logic                                rsp_valid,
   output logic signed [mm_pkg::VALUE_W-1:0]   rsp_result_value,
   output logic [mm_pkg::INDEX_W-1:0]          rsp_result_index,
   output logic                                rsp_result_last,

   // register port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mm_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [mm_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [mm_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                pready
);

   // size registers
   logic [mm_pkg::DIM_REG_W-1:0] row_count_ff, row_count_in;
   logic [mm_pkg::DIM_REG_W-1:0] inner_size_ff, inner_size_in;
   logic [mm_pkg::DIM_REG_W-1:0] col_count_ff, col_count_in;
   logic                         csr_write;
   logic [1:0]                   csr_sel;

   mm_pkg::cmd_type    cmd;
   mm_pkg::status_type status;

   assign pready    = 1'b1;
   // write lands on the access phase
   assign csr_write = psel && penable && pwrite && pready;
   // registers sit on word boundaries
   assign csr_sel   = paddr[3:2];

   always_comb begin
      row_count_in  = row_count_ff;
      inner_size_in = inner_size_ff;
      col_count_in  = col_count_ff;
      if (csr_write) begin
         case (csr_sel)
            mm_pkg::REG_ROW_COUNT:  row_count_in  = pwdata[mm_pkg::DIM_REG_W-1:0];
            mm_pkg::REG_INNER_SIZE: inner_size_in = pwdata[mm_pkg::DIM_REG_W-1:0];
            mm_pkg::REG_COL_COUNT:  col_count_in  = pwdata[mm_pkg::DIM_REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff  <= mm_pkg::DIM_REG_W'(mm_pkg::MAX_DIM);
         inner_size_ff <= mm_pkg::DIM_REG_W'(mm_pkg::MAX_DIM);
         col_count_ff  <= mm_pkg::DIM_REG_W'(mm_pkg::MAX_DIM);
      end else begin
         row_count_ff  <= row_count_in;
         inner_size_ff <= inner_size_in;
         col_count_ff  <= col_count_in;
      end
   end

   // read back, unused addresses read zero
   always_comb begin
      case (csr_sel)
         mm_pkg::REG_ROW_COUNT:
            prdata = mm_pkg::CSR_DATA_W'(row_count_ff);
         mm_pkg::REG_INNER_SIZE:
            prdata = mm_pkg::CSR_DATA_W'(inner_size_ff);
         mm_pkg::REG_COL_COUNT:
            prdata = mm_pkg::CSR_DATA_W'(col_count_ff);
         default:
            prdata = '0;
      endcase
   end

   // sequencer: walks i, j, k and drives stores and pipeline
   mm_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .opcode        (req_opcode),
      .element_index (req_element_index),
      .row_count     (row_count_ff),
      .inner_size    (inner_size_ff),
      .col_count     (col_count_ff),
      .status        (status),
      .busy          (busy),
      .cmd           (cmd)
   );

   // stores, multiplier, accumulator, rounding and clamp
   mm_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .element_value (req_element_value),
      .status        (status),
      .result_valid  (rsp_valid),
      .result_value  (rsp_result_value),
      .result_index  (rsp_result_index),
      .result_last   (rsp_result_last)
   );

   // a word only leaves during a compute run
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("result word outside a compute run");

   // the final word of a run is never followed directly by another
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_last |=> !rsp_valid)
      else $error("result word after the last one");

   // an accepted compute command starts a run
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_opcode == mm_pkg::OP_COMPUTE) |=> busy)
      else $error("compute command did not start a run");

endmodule
